>>> design/u8s_pkg.sv
// Package for the UTF-8 sequence splitter: widths, codes, item types and lead-byte decode.
package u8s_pkg;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 48;
	localparam int LEN_W = 3;
	localparam int MAX_SEQ_BYTES_DEF = 6;

	// Byte class boundaries and overlong floors.
	localparam logic [BYTE_W-1:0] ASCII_END = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD5_LO = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD6_LO = 8'hFC;
	localparam logic [BYTE_W-1:0] LEAD_END = 8'hFE;
	localparam logic [BYTE_W-1:0] CONT_LO = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_HI = 8'hBF;
	localparam logic [BYTE_W-1:0] FLOOR3 = 8'hA0;
	localparam logic [BYTE_W-1:0] FLOOR4 = 8'h90;
	localparam logic [BYTE_W-1:0] FLOOR5 = 8'h88;
	localparam logic [BYTE_W-1:0] FLOOR6 = 8'h84;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_string;
	} byte_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_bytes;
		logic [LEN_W-1:0]  char_length;
		status_t           status;
		logic              string_done;
	} char_item_t;

	// Sequence length announced by a lead byte; zero for a byte that cannot lead.
	function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] len;
		len = '0;
		priority if (b < ASCII_END) begin
			len = 3'd1;
		end else if (b < LEAD2_LO) begin
			len = 3'd0;
		end else if (b < LEAD3_LO) begin
			len = 3'd2;
		end else if (b < LEAD4_LO) begin
			len = 3'd3;
		end else if (b < LEAD5_LO) begin
			len = 3'd4;
		end else if (b < LEAD6_LO) begin
			len = 3'd5;
		end else if (b < LEAD_END) begin
			len = 3'd6;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

	// Lowest allowed second byte after a lead; raised only for the overlong-prone leads.
	function automatic logic [BYTE_W-1:0] lead_floor(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] fl;
		fl = CONT_LO;
		if (b == LEAD3_LO) begin
			fl = FLOOR3;
		end else if (b == LEAD4_LO) begin
			fl = FLOOR4;
		end else if (b == LEAD5_LO) begin
			fl = FLOOR5;
		end else if (b == LEAD6_LO) begin
			fl = FLOOR6;
		end
		return fl;
	endfunction

endpackage

>>> design/u8s_stream_ifs.sv
// Valid/ready stream interfaces for the byte input and the character output.
interface u8s_byte_if
	import u8s_pkg::*;
();
	logic       valid;
	logic       ready;
	byte_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface u8s_char_if
	import u8s_pkg::*;
();
	logic       valid;
	logic       ready;
	char_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/utf8_sequence_splitter_top.sv
// Top level of the UTF-8 sequence splitter: input register, decode against open state, result register.
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+-------------
//  bytes   | in  | in_byte[7:0], end_of_string                      | valid/ready
//  chars   | out | char_bytes[47:0], char_length[2:0], status[1:0], | valid/ready
//          |     | string_done                                      |
//
// One byte per cycle is accepted while the output is not stalled; each result passes
// through the input register and the result register. The only loop is the open-sequence
// state, updated once per byte. arst_n clears all valid flags and the sequence state;
// no clearing pass is needed. A stalled output holds its result and the input register,
// and bytes.ready drops only while both of them are full.
module utf8_sequence_splitter_top
	import u8s_pkg::*;
#(
	parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	u8s_byte_if.sink         bytes,
	u8s_char_if.source       chars
);

	localparam int GW = MAX_SEQ_BYTES * BYTE_W;

	// Input register.
	logic              valid_s1;
	byte_item_t        item_s1;

	// Open-sequence state.
	logic [GW-1:0]     gath_q;
	logic [LEN_W-1:0]  need_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] floor_q;
	logic              disc_q;

	// Result register.
	logic              out_valid_q;
	char_item_t        out_item_q;

	logic              proc;
	logic              advance;

	// Next state and result of the byte in the input register.
	logic [GW-1:0]     gath_d;
	logic [LEN_W-1:0]  need_d;
	logic [LEN_W-1:0]  cnt_d;
	logic [BYTE_W-1:0] floor_d;
	logic              disc_d;
	logic              res_valid;
	char_item_t        res_item;

	logic [LEN_W-1:0]  ld_len;
	logic [BYTE_W-1:0] lowest;
	logic [GW-1:0]     gath_sh;
	logic [LEN_W-1:0]  cnt_inc;
	logic [BYTE_W-1:0] b;
	logic              eos;

	// The stage can hand on a byte when the result register is free or is being read.
	assign advance = !out_valid_q || chars.ready;
	assign proc = valid_s1 && advance;
	assign bytes.ready = !valid_s1 || advance;

	assign b = item_s1.in_byte;
	assign eos = item_s1.end_of_string;
	assign ld_len = lead_len(b);
	assign lowest = (cnt_q == 3'd1) ? floor_q : CONT_LO;
	assign gath_sh = {gath_q[GW-BYTE_W-1:0], b};
	assign cnt_inc = cnt_q + 3'd1;

	// Decode of one byte against the open sequence.
	always_comb begin
		gath_d = gath_q;
		need_d = need_q;
		cnt_d = cnt_q;
		floor_d = floor_q;
		disc_d = disc_q;
		res_valid = 1'b0;
		res_item.char_bytes = '0;
		res_item.char_length = '0;
		res_item.status = ST_OK;
		res_item.string_done = eos;

		if (disc_q) begin
			if (eos) begin
				disc_d = 1'b0;
				gath_d = '0;
				need_d = '0;
				cnt_d = '0;
				floor_d = CONT_LO;
				res_valid = 1'b1;
				res_item.status = ST_INVALID;
			end
		end else if (need_q == '0) begin
			if (ld_len == '0 || ld_len > LEN_W'(MAX_SEQ_BYTES)) begin
				// Invalid lead byte.
				disc_d = !eos;
				res_valid = 1'b1;
				res_item.status = ST_INVALID;
			end else if (ld_len == 3'd1) begin
				res_valid = 1'b1;
				res_item.char_bytes = CHAR_W'(b);
				res_item.char_length = 3'd1;
			end else if (eos) begin
				// A lead as the last byte truncates the string.
				res_valid = 1'b1;
				res_item.status = ST_TRUNCATED;
			end else begin
				gath_d = GW'(b);
				need_d = ld_len;
				cnt_d = 3'd1;
				floor_d = lead_floor(b);
			end
		end else begin
			gath_d = '0;
			need_d = '0;
			cnt_d = '0;
			floor_d = CONT_LO;
			if (b < lowest || b > CONT_HI) begin
				// Bad continuation drops the partial character.
				disc_d = !eos;
				res_valid = 1'b1;
				res_item.status = ST_INVALID;
			end else if (cnt_inc >= need_q) begin
				res_valid = 1'b1;
				res_item.char_bytes = CHAR_W'(gath_sh);
				res_item.char_length = need_q;
			end else if (eos) begin
				res_valid = 1'b1;
				res_item.status = ST_TRUNCATED;
			end else begin
				gath_d = gath_sh;
				need_d = need_q;
				cnt_d = cnt_inc;
				floor_d = floor_q;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1 <= bytes.data;
		end
	end

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gath_q <= '0;
			need_q <= '0;
			cnt_q <= '0;
			floor_q <= CONT_LO;
			disc_q <= 1'b0;
		end else if (proc) begin
			gath_q <= gath_d;
			need_q <= need_d;
			cnt_q <= cnt_d;
			floor_q <= floor_d;
			disc_q <= disc_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			out_item_q <= res_item;
		end
	end

	assign chars.valid = out_valid_q;
	assign chars.data = out_item_q;

endmodule

>>> design/u8s_checker.sv
// Port-level assertions for the UTF-8 sequence splitter, bound to the top level.
module u8s_checker
	import u8s_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] char_bytes,
	input logic [LEN_W-1:0]  char_length,
	input logic [1:0]        status,
	input logic              string_done
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(char_bytes) && $stable(char_length) && $stable(status) &&
		$stable(string_done))
		else $error("result changed while stalled");

	// A character is present exactly when the status is good.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_OK) == (char_length != '0)))
		else $error("character length disagrees with status");

	// A truncation always closes the string.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TRUNCATED |-> string_done)
		else $error("truncation without end of string");

	// Error results carry no bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_length == '0 |-> char_bytes == '0)
		else $error("bytes on a result without a character");

endmodule

bind utf8_sequence_splitter_top u8s_checker u_u8s_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (chars.valid),
	.out_ready   (chars.ready),
	.char_bytes  (chars.data.char_bytes),
	.char_length (chars.data.char_length),
	.status      (chars.data.status),
	.string_done (chars.data.string_done)
);

>>> tb/utf8_split_checker.sv
`timescale 1ns / 100ps
// Checker for the UTF-8 splitter: predicts characters from accepted bytes and compares results.
module utf8_split_checker
	import u8s_pkg::*;
#(
	parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	u8s_byte_if  byte_ch,
	u8s_char_if  char_ch,
	output int   fail_count,
	output int   pending,
	output int   ok_chars,
	output int   invalid_results,
	output int   truncated_results
);
	localparam int REPORT_MAX = 10;

	// Open-sequence state of the predictor.
	logic [CHAR_W-1:0] seq_bytes;
	logic [LEN_W-1:0]  seq_len;
	logic [LEN_W-1:0]  seq_cnt;
	logic [BYTE_W-1:0] seq_floor;
	logic              dropping;

	char_item_t expected_chars[$];
	int errs = 0;
	int n_ok = 0;
	int n_bad = 0;
	int n_trunc = 0;

	function automatic void close_seq();
		seq_bytes = '0;
		seq_len = '0;
		seq_cnt = '0;
		seq_floor = 8'h80;
	endfunction

	// Adds a prediction behind the ones still waiting for their result.
	function automatic void queue_expected(input char_item_t item);
		expected_chars.insert(expected_chars.size(), item);
	endfunction

	// An error ends the character; the rest of the string is dropped unless this byte ends it.
	function automatic bit flag_invalid(input logic eos, output char_item_t res);
		close_seq();
		dropping = !eos;
		res = '0;
		res.status = ST_INVALID;
		res.string_done = eos;
		return 1'b1;
	endfunction

	function automatic bit flag_truncated(output char_item_t res);
		close_seq();
		res = '0;
		res.status = ST_TRUNCATED;
		res.string_done = 1'b1;
		return 1'b1;
	endfunction

	// Advances the predicted state by one byte; returns 1 when the byte yields a result.
	function automatic bit decode_byte(input byte_item_t req, output char_item_t res);
		logic [BYTE_W-1:0] b;
		logic              eos;
		int                len;
		logic [BYTE_W-1:0] fl;
		logic [BYTE_W-1:0] lowest;
		b = req.in_byte;
		eos = req.end_of_string;
		res = '0;
		// While dropping a failed string, only its last byte answers.
		if (dropping) begin
			if (!eos) begin
				return 1'b0;
			end
			dropping = 1'b0;
			close_seq();
			res.status = ST_INVALID;
			res.string_done = 1'b1;
			return 1'b1;
		end
		// No sequence open: classify the lead byte and its overlong floor.
		if (seq_len == '0) begin
			fl = 8'h80;
			if (b < 8'h80) begin
				len = 1;
			end else if (b < 8'hC2) begin
				len = 0;
			end else if (b < 8'hE0) begin
				len = 2;
			end else if (b < 8'hF0) begin
				len = 3;
				if (b == 8'hE0) fl = 8'hA0;
			end else if (b < 8'hF8) begin
				len = 4;
				if (b == 8'hF0) fl = 8'h90;
			end else if (b < 8'hFC) begin
				len = 5;
				if (b == 8'hF8) fl = 8'h88;
			end else if (b < 8'hFE) begin
				len = 6;
				if (b == 8'hFC) fl = 8'h84;
			end else begin
				len = 0;
			end
			if (len == 0 || len > MAX_SEQ_BYTES) begin
				return flag_invalid(eos, res);
			end
			if (len == 1) begin
				res.char_bytes = CHAR_W'(b);
				res.char_length = LEN_W'(1);
				res.string_done = eos;
				return 1'b1;
			end
			seq_bytes = CHAR_W'(b);
			seq_len = LEN_W'(len);
			seq_cnt = LEN_W'(1);
			seq_floor = fl;
			if (eos) begin
				return flag_truncated(res);
			end
			return 1'b0;
		end
		// Continuation byte: range check, with the floor on the second byte.
		lowest = (seq_cnt == LEN_W'(1)) ? seq_floor : 8'h80;
		if (b < lowest || b > 8'hBF) begin
			return flag_invalid(eos, res);
		end
		seq_bytes = {seq_bytes[CHAR_W-BYTE_W-1:0], b};
		seq_cnt = seq_cnt + LEN_W'(1);
		if (seq_cnt >= seq_len) begin
			res.char_bytes = seq_bytes;
			res.char_length = seq_len;
			res.string_done = eos;
			close_seq();
			return 1'b1;
		end
		if (eos) begin
			return flag_truncated(res);
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		char_item_t res;
		char_item_t got;
		char_item_t want;
		if (!arst_n) begin
			close_seq();
			dropping = 1'b0;
			expected_chars.delete();
		end else begin
			// Predict on every accepted byte request.
			if (byte_ch.valid && byte_ch.ready) begin
				if (decode_byte(byte_ch.data, res)) begin
					queue_expected(res);
				end
			end
			// Compare every accepted character request with the oldest prediction.
			if (char_ch.valid && char_ch.ready) begin
				got = char_ch.data;
				if (expected_chars.size() == 0) begin
					errs++;
					if (errs <= REPORT_MAX) begin
						$display("%0t: unexpected result bytes=%h len=%0d status=%0d done=%0d",
							$time, got.char_bytes, got.char_length, got.status,
							got.string_done);
					end
				end else begin
					want = expected_chars.pop_front();
					case (want.status)
						ST_OK: n_ok++;
						ST_INVALID: n_bad++;
						default: n_trunc++;
					endcase
					if (got.char_bytes !== want.char_bytes || got.char_length !== want.char_length
						|| got.status !== want.status || got.string_done !== want.string_done) begin
						errs++;
						if (errs <= REPORT_MAX) begin
							$display("%0t: mismatch expected bytes=%h len=%0d status=%0d done=%0d",
								$time, want.char_bytes, want.char_length, want.status,
								want.string_done);
							$display("%0t:          actual   bytes=%h len=%0d status=%0d done=%0d",
								$time, got.char_bytes, got.char_length, got.status,
								got.string_done);
						end
					end
				end
			end
		end
		pending <= expected_chars.size();
		fail_count <= errs;
		ok_chars <= n_ok;
		invalid_results <= n_bad;
		truncated_results <= n_trunc;
	end

endmodule

>>> tb/utf8_sequence_splitter_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-8 splitter: clock, reset, byte stimulus, receiver stalls and verdict.
module utf8_sequence_splitter_top_tb;
	import u8s_pkg::*;

	localparam int RANDOM_BYTES = 375;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT = 28;

	logic clk;
	logic arst_n;
	bit   gaps_on = 1'b1;
	int   sent_bytes = 0;
	int   sent_strings = 0;
	int   cycle_cnt = 0;
	int   last_len = 1;
	logic [BYTE_W-1:0] str_buf[$];

	int fail_count;
	int pending;
	int ok_chars;
	int invalid_results;
	int truncated_results;

	u8s_byte_if byte_ch ();
	u8s_char_if char_ch ();

	utf8_sequence_splitter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.chars  (char_ch)
	);

	utf8_split_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_ch           (byte_ch),
		.char_ch           (char_ch),
		.fail_count        (fail_count),
		.pending           (pending),
		.ok_chars          (ok_chars),
		.invalid_results   (invalid_results),
		.truncated_results (truncated_results)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Receiver stalls at random, except during the full-rate stretch.
	always @(posedge clk) begin
		char_ch.ready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
	end

	// Adds one byte at the end of the string being built.
	function automatic void append_byte(input logic [BYTE_W-1:0] b);
		str_buf.insert(str_buf.size(), b);
	endfunction

	// Presents one byte request, with random idle cycles ahead of it, and waits for acceptance.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data <= '{in_byte: b, end_of_string: eos};
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		sent_bytes++;
		if (eos) sent_strings++;
	endtask

	// Appends one well-formed character of random length; overlong-prone leads are favored.
	task automatic add_char();
		logic [BYTE_W-1:0] lead;
		logic [BYTE_W-1:0] lo;
		int                len;
		len = $urandom_range(MAX_SEQ_BYTES_DEF, 1);
		case (len)
			1: lead = 8'($urandom_range(8'h7F));
			2: lead = 8'($urandom_range(8'hDF, 8'hC2));
			3: lead = ($urandom_range(2) == 0) ? 8'hE0 : 8'($urandom_range(8'hEF, 8'hE0));
			4: lead = ($urandom_range(2) == 0) ? 8'hF0 : 8'($urandom_range(8'hF7, 8'hF0));
			5: lead = ($urandom_range(2) == 0) ? 8'hF8 : 8'($urandom_range(8'hFB, 8'hF8));
			default: lead = ($urandom_range(2) == 0) ? 8'hFC : 8'($urandom_range(8'hFD, 8'hFC));
		endcase
		append_byte(lead);
		for (int k = 1; k < len; k++) begin
			lo = 8'h80;
			if (k == 1) begin
				case (lead)
					8'hE0: lo = 8'hA0;
					8'hF0: lo = 8'h90;
					8'hF8: lo = 8'h88;
					8'hFC: lo = 8'h84;
					default: lo = 8'h80;
				endcase
			end
			case ($urandom_range(3))
				0: append_byte(lo);
				1: append_byte(8'hBF);
				default: append_byte(8'($urandom_range(8'hBF, lo)));
			endcase
		end
		last_len = len;
	endtask

	// Run limit.
	initial begin
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("utf8_sequence_splitter_top regression: fail");
		$finish;
	end

	initial begin
		int first_random;
		int kind;
		int pos;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data = '0;
		char_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ASCII extremes; the second one closes the string.
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		// Bytes that cannot lead, alone and followed by a dropped tail.
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'hC1, 1'b1);
		send_byte(8'hFE, 1'b1);
		// Shortest two-byte character.
		send_byte(8'hC2, 1'b0);
		send_byte(8'h80, 1'b1);
		// Second byte below the floor after E0; the rest of the string is dropped.
		send_byte(8'hE0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h00, 1'b1);
		// Six-byte character starting at its floor and ending on the top continuation.
		send_byte(8'hFC, 1'b0);
		send_byte(8'h84, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b1);
		// Below-floor second byte after F8 on the final byte.
		send_byte(8'hF8, 1'b0);
		send_byte(8'h87, 1'b1);
		// Continuation above the allowed range.
		send_byte(8'hDF, 1'b0);
		send_byte(8'hC0, 1'b1);
		// Truncated ends: a lone lead, and a lead with one continuation.
		send_byte(8'hC2, 1'b1);
		send_byte(8'hE1, 1'b0);
		send_byte(8'h80, 1'b1);

		// Random strings: mostly well-formed, some corrupted, truncated or pure noise.
		first_random = sent_bytes;
		while (sent_bytes < first_random + RANDOM_BYTES) begin
			gaps_on <= !(sent_bytes >= first_random + 200 && sent_bytes < first_random + 300);
			str_buf.delete();
			kind = $urandom_range(99);
			if (kind < 10) begin
				repeat ($urandom_range(6, 1)) append_byte(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(5, 1)) add_char();
				if (kind < 22) begin
					pos = $urandom_range(str_buf.size() - 1);
					str_buf[pos] = 8'($urandom_range(255));
				end else if (kind < 32) begin
					if (last_len > 1) begin
						repeat ($urandom_range(last_len - 1, 1)) void'(str_buf.pop_back());
					end else begin
						append_byte(8'($urandom_range(8'hFD, 8'hC2)));
					end
				end
			end
			foreach (str_buf[i]) send_byte(str_buf[i], i == str_buf.size() - 1);
		end
		byte_ch.valid <= 1'b0;

		// Drain the remaining results, then allow for the pipeline latency.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d strings, with random gaps and a full-rate stretch.",
			sent_bytes, sent_strings);
		$display("Checked %0d characters, %0d invalid and %0d truncated string results.",
			ok_chars, invalid_results, truncated_results);
		if (fail_count == 0 && pending == 0) begin
			$display("utf8_sequence_splitter_top regression: pass");
		end else begin
			$display("utf8_sequence_splitter_top regression: fail");
		end
		$finish;
	end

endmodule
